// File: src/pbt_pkg.sv
// Shared types and constants for the per-peer backoff table.
// No dependencies; pbt_limits, pbt_update and the top level import this package.
`default_nettype none
package pbt_pkg;

    localparam int unsigned DEFAULT_PEERS = 256;
    localparam int unsigned MAX_REACH     = 256;

    localparam int unsigned MIN_W   = 22;
    localparam int unsigned DELAY_W = 32;
    localparam int unsigned CFG_IW  = 2;

    localparam logic [MIN_W-1:0]   FLOOR_MIN  = 22'd100;
    localparam logic [9:0]         MAX_FACTOR = 10'd1000;

    localparam logic [MIN_W-1:0]   RST_MIN  = 22'd100;
    localparam logic [DELAY_W-1:0] RST_MAX  = 32'd100000;
    localparam logic [DELAY_W-1:0] RST_INIT = 32'd50050;

    localparam logic [CFG_IW-1:0] CFG_MIN  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_INIT = 2'd2;

    localparam logic FUNC_FETCH = 1'b0;
    localparam logic FUNC_ACK   = 1'b1;

    typedef struct packed {
        logic [MIN_W-1:0]   lo;
        logic [DELAY_W-1:0] hi;
        logic [DELAY_W-1:0] first;
    } t_limits;

    typedef struct packed {
        logic               we;
        logic [DELAY_W-1:0] wdata;
        logic [DELAY_W-1:0] result;
    } t_update;

endpackage
`default_nettype wire

// File: src/pbt_mem.sv
// Delay store: single-port-write, single-port-read RAM with a registered read.
// Depends on nothing beyond its parameters.
`default_nettype none
module pbt_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: src/pbt_limits.sv
// Configuration registers and the registered derivation of the effective limits.
// Depends on pbt_pkg.
`default_nettype none
module pbt_limits (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pbt_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [31:0]                i_cfg_data,
    output pbt_pkg::t_limits                o_lim,
    output logic                            o_settled
);
    import pbt_pkg::*;

    logic [MIN_W-1:0]   r_min_cfg;
    logic [DELAY_W-1:0] r_max_cfg;
    logic [DELAY_W-1:0] r_init_cfg;
    logic [MIN_W-1:0]   r_mn;
    logic [DELAY_W-1:0] r_big;
    logic [DELAY_W-1:0] r_hi;
    logic [DELAY_W-1:0] r_first;
    logic [1:0]         r_settle;

    logic               cfg_wr;
    logic [MIN_W-1:0]   n_mn;
    logic [DELAY_W-1:0] n_hi;
    logic [DELAY_W-1:0] n_first;
    logic [DELAY_W-1:0] mn_ext;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_mn    = (r_min_cfg < FLOOR_MIN) ? FLOOR_MIN : r_min_cfg;
        n_hi    = (r_max_cfg < r_big) ? r_big : r_max_cfg;
        mn_ext  = DELAY_W'(r_mn);
        n_first = r_init_cfg;
        if ((r_init_cfg < mn_ext) || (r_init_cfg > r_hi)) begin
            n_first = (mn_ext >> 1) + (r_hi >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cfg  <= RST_MIN;
            r_max_cfg  <= RST_MAX;
            r_init_cfg <= RST_INIT;
            r_settle   <= 2'd3;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_MIN:  r_min_cfg  <= i_cfg_data[MIN_W-1:0];
                    CFG_MAX:  r_max_cfg  <= i_cfg_data;
                    CFG_INIT: r_init_cfg <= i_cfg_data;
                    default:  ;
                endcase
                r_settle <= 2'd3;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mn    <= n_mn;
        r_big   <= DELAY_W'(n_mn * MAX_FACTOR);
        r_hi    <= n_hi;
        r_first <= n_first;
    end

    assign o_lim.lo    = r_mn;
    assign o_lim.hi    = r_hi;
    assign o_lim.first = r_first;
    assign o_settled   = (r_settle == 2'd0);

    a_cfg_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !o_settled)
        else $error("limits reported settled straight after a register write");

endmodule
`default_nettype wire

// File: src/pbt_update.sv
// Modify step of the read-modify-write: doubles, halves or creates an entry, or writes nothing.
// Depends on pbt_pkg.
`default_nettype none
module pbt_update (
    input  wire logic                        i_func,
    input  wire logic                        i_known,
    input  wire logic [pbt_pkg::DELAY_W-1:0] i_data,
    input  wire pbt_pkg::t_limits            i_lim,
    output pbt_pkg::t_update                 o_upd
);
    import pbt_pkg::*;

    logic [DELAY_W:0]   dbl;
    logic [DELAY_W-1:0] half;
    logic [DELAY_W-1:0] lo_ext;

    always_comb begin
        dbl    = {i_data, 1'b0};
        half   = i_data >> 1;
        lo_ext = DELAY_W'(i_lim.lo);
        o_upd  = '0;
        if (i_func == FUNC_FETCH) begin
            o_upd.we = 1'b1;
            if (!i_known) begin
                o_upd.wdata  = i_lim.first;
                o_upd.result = i_lim.first;
            end else begin
                o_upd.result = i_data;
                o_upd.wdata  = (dbl > {1'b0, i_lim.hi}) ? i_lim.hi : dbl[DELAY_W-1:0];
            end
        end else if (i_known) begin
            o_upd.we     = 1'b1;
            o_upd.wdata  = (half < lo_ext) ? lo_ext : half;
            o_upd.result = o_upd.wdata;
        end
    end

endmodule
`default_nettype wire

// File: src/per_peer_backoff_table_unit.sv
// Top level of the per-peer backoff table: input stage, valid bits, forwarding, output register.
// Depends on pbt_pkg, pbt_limits, pbt_mem and pbt_update.
//
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_func, i_peer_index
// out       source     o_out_valid / i_out_stall   o_delay_us, o_entry_known
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// The table read of an item is issued in the cycle it is accepted; the modify stage then does
// the modify, write-back and output load. One item can be accepted every cycle unless stalled.
// A write to the same peer in the cycle of the next read is forwarded from a register.
// After reset and after each register write the limit derivation stalls the input until it has
// settled. Valid bits are cleared by reset at once.
// A stalled output holds the modify stage, which in turn stalls the input.
`default_nettype none
module per_peer_backoff_table_unit #(
    parameter int unsigned PEERS = pbt_pkg::DEFAULT_PEERS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_func,
    input  wire logic [7:0]                  i_peer_index,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [pbt_pkg::DELAY_W-1:0] o_delay_us,
    output logic                             o_entry_known,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [pbt_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data
);
    import pbt_pkg::*;

    localparam int unsigned DEPTH = (PEERS < MAX_REACH) ? PEERS : MAX_REACH;
    localparam int unsigned IW    = $clog2(DEPTH);

    logic [IW-1:0]      w_idx_tab [MAX_REACH];
    logic [IW-1:0]      w_idx;
    logic [DEPTH-1:0]   r_valid;
    logic               r_s1_valid;
    logic               r_s1_func;
    logic [IW-1:0]      r_s1_idx;
    logic               r_byp;
    logic [DELAY_W-1:0] r_byp_data;
    logic               r_out_valid;
    logic [DELAY_W-1:0] r_out_delay;
    logic               r_out_known;

    logic               in_acc;
    logic               s1_adv;
    logic               s1_known;
    logic               settled;
    logic [DELAY_W-1:0] rd_data;
    logic [DELAY_W-1:0] s1_data;
    t_limits            lim;
    t_update            upd;

    for (genvar g = 0; g < MAX_REACH; g++) begin : g_idx
        assign w_idx_tab[g] = IW'(g % DEPTH);
    end

    assign w_idx    = w_idx_tab[i_peer_index];
    assign s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !settled || (r_s1_valid && !s1_adv);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign s1_known = r_valid[r_s1_idx];
    assign s1_data  = r_byp ? r_byp_data : rd_data;

    pbt_limits u_limits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lim       (lim),
        .o_settled   (settled)
    );

    pbt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (DELAY_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (w_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv && upd.we),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (upd.wdata)
    );

    pbt_update u_update (
        .i_func  (r_s1_func),
        .i_known (s1_known),
        .i_data  (s1_data),
        .i_lim   (lim),
        .o_upd   (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            if (s1_adv && upd.we) begin
                r_valid[r_s1_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv && upd.we && (r_s1_idx == w_idx);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func  <= i_func;
            r_s1_idx   <= w_idx;
            r_byp_data <= upd.wdata;
        end
        if (s1_adv) begin
            r_out_delay <= upd.result;
            r_out_known <= s1_known;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_delay_us    = r_out_delay;
    assign o_entry_known = r_out_known;

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && upd.we) |=> r_valid[$past(r_s1_idx)])
        else $error("table write did not mark its entry valid");

    a_ack_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_s1_func == FUNC_ACK) && !s1_known) |=>
        ((o_delay_us == '0) && !o_entry_known))
        else $error("acknowledge of an unknown peer gave a non-zero result");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("output beat appeared without an item in the modify stage");

    a_no_accept_unsettled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!settled && r_s1_valid) |-> s1_adv || i_out_stall)
        else $error("modify stage held without an output stall");

endmodule
`default_nettype wire
